/* rtl/core/psta_pkg.sv */
// ----------------------------------------------------------------------------
// Peer station table package
// Shared types, command and status codes for the peer station table.
// ----------------------------------------------------------------------------
package psta_pkg;

  // Default number of table slots.
  localparam int DEFAULT_TABLE_DEPTH = 32;

  // Command codes carried in func.
  localparam logic [1:0] FUNC_REPORT = 2'd0;
  localparam logic [1:0] FUNC_SWEEP  = 2'd1;
  localparam logic [1:0] FUNC_MARK   = 2'd2;

  // Status codes of a result word.
  localparam logic [2:0] STATUS_UPDATED   = 3'd0;
  localparam logic [2:0] STATUS_INSERTED  = 3'd1;
  localparam logic [2:0] STATUS_FULL      = 3'd2;
  localparam logic [2:0] STATUS_SWEPT     = 3'd3;
  localparam logic [2:0] STATUS_MARKED    = 3'd4;
  localparam logic [2:0] STATUS_NOT_FOUND = 3'd5;

  // Register offsets of the configuration port (byte address bit 2 selects).
  localparam logic REG_OFFLINE_SECONDS = 1'b0;
  localparam logic [31:0] OFFLINE_SECONDS_RESET = 32'd60;

  // Rate in kbps to Mbps: the rate shifted right by 3 is multiplied by a
  // rounded-up reciprocal of 125, and the quotient starts at product bit
  // RECIP_125_SHIFT. The result is exact for every 32-bit rate.
  localparam logic [29:0] RECIP_125 = 30'd549755814;
  localparam int RECIP_125_SHIFT = 36;
  localparam int RATE_W = 23;

  // Phy mode codes at or above this limit are stored as 11B.
  localparam logic [7:0] MODE_LIMIT = 8'd22;
  localparam logic [4:0] MODE_11B   = 5'd2;

  // Fixed point reciprocal of 5 for 16-bit dividends (product bits 31:18).
  localparam logic [15:0] RECIP_5 = 16'hCCCD;

  // Per-entry data that is stored but not needed for lookup or aging.
  typedef struct packed {
    logic [7:0]        rssi;
    logic [RATE_W-1:0] tx_mbps;
    logic [RATE_W-1:0] rx_mbps;
    logic [31:0]       assoc_time;
    logic [8:0]        channel;
    logic [4:0]        mode;
  } entry_info_t;

endpackage

/* rtl/core/peer_station_table_aging.sv */
// ----------------------------------------------------------------------------
// Peer station table with aging
// MAC-keyed table of peer stations with report, whitelist mark and sweep.
// ----------------------------------------------------------------------------
// One word is taken at a time; in_stall stays high until its result has been
// loaded into the output register. Every command except an unknown func walks
// the table one slot per cycle through the MAC and last-seen memories. A report
// that updates or inserts an entry then divides both rates by 1000 on one
// shared reciprocal multiplier, one rate per cycle, and writes the entry. A
// report on a full table skips the division and the write, and an unknown func
// skips the table walk.
// Reset only clears the valid bits, so no clearing pass is needed.
module peer_station_table_aging #(
  parameter int TABLE_DEPTH = psta_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [47:0] mac_address,
  input  logic [7:0]  signal_strength,
  input  logic [31:0] tx_rate_kbps,
  input  logic [7:0]  legacy_rate_code,
  input  logic [31:0] rx_rate_kbps,
  input  logic [31:0] assoc_seconds,
  input  logic [15:0] freq_mhz,
  input  logic [7:0]  phy_mode,
  input  logic [31:0] now_seconds,
  input  logic        whitelist_bit,
  // Output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [4:0]  slot_index,
  output logic [5:0]  removed_count,
  output logic [8:0]  channel_number
);
  import psta_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_DEPTH - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state;

  // Configuration register and port.
  logic [31:0] offline_seconds;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_OFFLINE_SECONDS) ? offline_seconds : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      offline_seconds <= OFFLINE_SECONDS_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_OFFLINE_SECONDS) begin
      offline_seconds <= pwdata;
    end
  end

  // Captured input word.
  logic [1:0]  func_q;
  logic [47:0] mac_q;
  logic [7:0]  rssi_q;
  logic [31:0] txk_q;
  logic [7:0]  legacy_q;
  logic [31:0] rxk_q;
  logic [31:0] assoc_q;
  logic [15:0] freq_q;
  logic [7:0]  mode_q;
  logic [31:0] now_q;
  logic        wl_bit_q;

  logic accept;
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q   <= func;
      mac_q    <= mac_address;
      rssi_q   <= signal_strength;
      txk_q    <= tx_rate_kbps;
      legacy_q <= legacy_rate_code;
      rxk_q    <= rx_rate_kbps;
      assoc_q  <= assoc_seconds;
      freq_q   <= freq_mhz;
      mode_q   <= phy_mode;
      now_q    <= now_seconds;
      wl_bit_q <= whitelist_bit;
    end
  end

  // Channel from frequency: two reciprocal multiplies by 1/5 plus selection.
  logic [15:0] ch_num;
  logic [31:0] ch_prod;
  logic [13:0] ch_quot;
  logic [5:0]  band_d;
  logic [9:0]  band_prod;
  logic [3:0]  band_q5;
  logic [5:0]  band_r5;
  logic [13:0] ch_full;
  logic [8:0]  ch_sat;

  always_comb begin
    band_d    = 6'(freq_q - 16'd4940);
    band_prod = 10'(band_d) * 10'd13;
    band_q5   = band_prod[9:6];
    band_r5   = band_d - 6'(band_q5) * 6'd5;
    priority if (freq_q < 16'd2484) begin
      ch_num = freq_q - 16'd2407;
    end else if (freq_q >= 16'd5000) begin
      ch_num = freq_q - 16'd5000;
    end else if (freq_q > 16'd4900) begin
      ch_num = freq_q - 16'd4000;
    end else begin
      ch_num = freq_q - 16'd2512;
    end
    ch_prod = 32'(ch_num) * 32'(RECIP_5);
    ch_quot = ch_prod[31:18];
    priority if (freq_q == 16'd2484) begin
      ch_full = 14'd14;
    end else if (freq_q < 16'd2407) begin
      ch_full = 14'd0;
    end else if (freq_q < 16'd2484) begin
      ch_full = ch_quot;
    end else if (freq_q >= 16'd5000) begin
      ch_full = ch_quot;
    end else if (freq_q > 16'd4940 && freq_q < 16'd4990) begin
      ch_full = {7'd0, band_d, 1'b0} + ((band_r5 == 6'd2) ? 14'd1 : 14'd0);
    end else if (freq_q > 16'd4900) begin
      ch_full = ch_quot;
    end else if (freq_q < 16'd2512) begin
      ch_full = 14'd0;
    end else begin
      ch_full = 14'd15 + {2'd0, ch_quot[13:2]};
    end
    ch_sat = (ch_full > 14'd511) ? 9'd511 : ch_full[8:0];
  end

  // Table storage: valid and whitelist bits in flops, the rest in memories.
  logic [TABLE_DEPTH-1:0] entry_valid;
  logic [TABLE_DEPTH-1:0] entry_whitelisted;
  logic [47:0]       mac_mem  [TABLE_DEPTH];
  logic [31:0]       seen_mem [TABLE_DEPTH];
  entry_info_t       info_mem [TABLE_DEPTH];

  // Scan pipeline: read slot rd_idx, compare it in the next cycle.
  logic [IW-1:0] rd_idx;
  logic [IW-1:0] cmp_idx;
  logic          pend;
  logic [47:0]   rd_mac;
  logic [31:0]   rd_seen;
  logic [8:0]    chan;

  always_ff @(posedge clk) begin
    rd_mac  <= mac_mem[rd_idx];
    rd_seen <= seen_mem[rd_idx];
  end

  logic        hit_here, free_here, stale_here;
  logic [31:0] age;

  always_comb begin
    age        = now_q - rd_seen;
    hit_here   = pend && entry_valid[cmp_idx] && rd_mac == mac_q;
    free_here  = pend && !entry_valid[cmp_idx];
    stale_here = pend && entry_valid[cmp_idx] && !entry_whitelisted[cmp_idx] &&
                 age > offline_seconds;
  end

  logic          found, free_found;
  logic [IW-1:0] hit_slot, free_slot;
  logic [CW-1:0] removed;
  logic          found_fin, free_fin;
  logic [IW-1:0] hit_fin, free_slot_fin;

  always_comb begin
    found_fin     = found || hit_here;
    hit_fin       = found ? hit_slot : cmp_idx;
    free_fin      = free_found || free_here;
    free_slot_fin = free_found ? free_slot : cmp_idx;
  end

  // Shared reciprocal multiplier: each rate divided by 1000, one per cycle.
  logic              div_sel;
  logic [31:0]       div_src;
  logic [58:0]       div_prod;
  logic [RATE_W-1:0] quo_tx, quo_rx;

  always_comb begin
    div_src  = div_sel ? rxk_q : txk_q;
    div_prod = 59'(div_src[31:3]) * 59'(RECIP_125);
  end

  // Result being built and the slot to write.
  logic [2:0]    res_status;
  logic [IW-1:0] res_slot;
  logic          res_has_slot;
  logic          do_insert;
  entry_info_t   info_wr;

  always_comb begin
    info_wr.rssi       = rssi_q;
    info_wr.tx_mbps    = (txk_q == 32'd0) ? RATE_W'(legacy_q[6:1]) : quo_tx;
    info_wr.rx_mbps    = quo_rx;
    info_wr.assoc_time = assoc_q;
    info_wr.channel    = chan;
    info_wr.mode       = (mode_q >= MODE_LIMIT) ? MODE_11B : mode_q[4:0];
  end

  // Table memory writes.
  always_ff @(posedge clk) begin
    if (state == ST_WRITE) begin
      mac_mem[res_slot]  <= mac_q;
      seen_mem[res_slot] <= now_q;
      info_mem[res_slot] <= info_wr;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      entry_valid  <= '0;
      pend         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            rd_idx     <= '0;
            pend       <= 1'b0;
            found      <= 1'b0;
            free_found <= 1'b0;
            removed    <= '0;
            res_has_slot <= 1'b0;
            do_insert  <= 1'b0;
            if (func == FUNC_REPORT || func == FUNC_SWEEP || func == FUNC_MARK) begin
              state <= ST_SCAN;
            end else begin
              res_status <= STATUS_NOT_FOUND;
              state      <= ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          chan    <= ch_sat;
          pend    <= 1'b1;
          cmp_idx <= rd_idx;
          if (rd_idx != LAST_SLOT) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (hit_here && !found) begin
            found    <= 1'b1;
            hit_slot <= cmp_idx;
          end
          if (free_here && !free_found) begin
            free_found <= 1'b1;
            free_slot  <= cmp_idx;
          end
          if (func_q == FUNC_SWEEP && stale_here) begin
            entry_valid[cmp_idx] <= 1'b0;
            removed              <= removed + 1'b1;
          end
          // Last slot compared: decide the outcome.
          if (pend && cmp_idx == LAST_SLOT) begin
            unique case (func_q)
              FUNC_REPORT: begin
                if (found_fin || free_fin) begin
                  res_status   <= found_fin ? STATUS_UPDATED : STATUS_INSERTED;
                  res_slot     <= found_fin ? hit_fin : free_slot_fin;
                  res_has_slot <= 1'b1;
                  do_insert    <= !found_fin;
                  div_sel      <= 1'b0;
                  state        <= ST_DIV;
                end else begin
                  res_status <= STATUS_FULL;
                  state      <= ST_DONE;
                end
              end
              FUNC_SWEEP: begin
                res_status <= STATUS_SWEPT;
                state      <= ST_DONE;
              end
              FUNC_MARK: begin
                if (found_fin) begin
                  entry_whitelisted[hit_fin] <= wl_bit_q;
                  res_status   <= STATUS_MARKED;
                  res_slot     <= hit_fin;
                  res_has_slot <= 1'b1;
                end else begin
                  res_status <= STATUS_NOT_FOUND;
                end
                state <= ST_DONE;
              end
              default: begin
                res_status <= STATUS_NOT_FOUND;
                state      <= ST_DONE;
              end
            endcase
          end
        end
        ST_DIV: begin
          // The tx rate goes through the multiplier first, then the rx rate.
          if (!div_sel) begin
            quo_tx  <= div_prod[RECIP_125_SHIFT +: RATE_W];
            div_sel <= 1'b1;
          end else begin
            quo_rx <= div_prod[RECIP_125_SHIFT +: RATE_W];
            state  <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (do_insert) begin
            entry_valid[res_slot]       <= 1'b1;
            entry_whitelisted[res_slot] <= 1'b0;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            status         <= res_status;
            slot_index     <= res_has_slot ? 5'(res_slot) : 5'd0;
            removed_count  <= (func_q == FUNC_SWEEP) ?
                              ((removed > CW'(63)) ? 6'd63 : 6'(removed)) : 6'd0;
            channel_number <= (func_q == FUNC_REPORT) ? chan : 9'd0;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // A full table is only reported when every slot holds an entry.
  a_full_means_no_free: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && status == STATUS_FULL |-> &entry_valid)
    else $error("table full reported with a free slot");

  // Only a sweep reports removed entries.
  a_removed_only_sweep: assert property (@(posedge clk) disable iff (rst)
    out_valid && removed_count != 6'd0 |-> status == STATUS_SWEPT)
    else $error("removed count on a non-sweep result");

  // The divider only runs for a report that found or took a slot.
  a_div_for_report: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> func_q == FUNC_REPORT && res_has_slot)
    else $error("divider running without a report slot");

  // After an insert the written slot is valid.
  a_insert_sets_valid: assert property (@(posedge clk) disable iff (rst)
    state == ST_WRITE |=> entry_valid[$past(res_slot)])
    else $error("written slot not valid");
`endif

endmodule

/* tb/peer_station_table_aging_test.sv */
// ----------------------------------------------------------------------------
// Peer station table aging testbench
// Drives station reports, whitelist marks and aging sweeps into the table,
// predicts every result word from a shadow copy of the table and checks the
// output words in order, under several idle and stall mixes and settings of
// the offline limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module peer_station_table_aging_test;
  import psta_pkg::*;

  localparam int DEPTH = DEFAULT_TABLE_DEPTH;
  localparam logic [2:0] ADDR_OFFLINE = {REG_OFFLINE_SECONDS, 2'b00};

  typedef struct packed {
    logic [1:0]  func;
    logic [47:0] mac;
    logic [7:0]  rssi;
    logic [31:0] tx_kbps;
    logic [7:0]  legacy;
    logic [31:0] rx_kbps;
    logic [31:0] assoc;
    logic [15:0] freq;
    logic [7:0]  mode;
    logic [31:0] now;
    logic        wl;
  } command_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] slot;
    logic [5:0] removed;
    logic [8:0] channel;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  command_t cur = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] status;
  logic [4:0] slot_index;
  logic [5:0] removed_count;
  logic [8:0] channel_number;

  command_t pending_cmds[$];
  answer_t expected_answers[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  // Shadow copy of the table and the offline limit.
  logic        tbl_valid[DEPTH];
  logic [47:0] tbl_mac[DEPTH];
  logic        tbl_wl[DEPTH];
  logic [31:0] tbl_seen[DEPTH];
  logic [31:0] offline_limit;
  logic [47:0] known_macs[$];

  peer_station_table_aging dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(cur.func), .mac_address(cur.mac), .signal_strength(cur.rssi),
    .tx_rate_kbps(cur.tx_kbps), .legacy_rate_code(cur.legacy),
    .rx_rate_kbps(cur.rx_kbps), .assoc_seconds(cur.assoc),
    .freq_mhz(cur.freq), .phy_mode(cur.mode), .now_seconds(cur.now),
    .whitelist_bit(cur.wl),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .slot_index(slot_index),
    .removed_count(removed_count), .channel_number(channel_number)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Channel number for a frequency in MHz, saturated at 511.
  function automatic logic [8:0] channel_of(input logic [15:0] freq);
    int unsigned f, ch;
    f = 32'(freq);
    if (f == 2484) ch = 14;
    else if (f < 2484) ch = (f < 2407) ? 0 : (f - 2407) / 5;
    else if (f < 5000) begin
      if (f > 4940 && f < 4990) ch = (f * 10 + ((f % 5) == 2 ? 5 : 0) - 49400) / 5;
      else if (f > 4900) ch = (f - 4000) / 5;
      else ch = (f < 2512) ? 0 : 15 + (f - 2512) / 20;
    end else ch = (f - 5000) / 5;
    return (ch > 511) ? 9'd511 : ch[8:0];
  endfunction

  function automatic int slot_of(input logic [47:0] mac);
    for (int i = 0; i < DEPTH; i++)
      if (tbl_valid[i] && tbl_mac[i] == mac) return i;
    return -1;
  endfunction

  // Apply one command to the shadow table and return its result word.
  function automatic answer_t table_update(input command_t c);
    answer_t a;
    int s;
    logic [31:0] age;
    a = '{status: STATUS_NOT_FOUND, slot: '0, removed: '0, channel: '0};
    case (c.func)
      FUNC_REPORT: begin
        a.channel = channel_of(c.freq);
        s = slot_of(c.mac);
        if (s >= 0) a.status = STATUS_UPDATED;
        else begin
          for (int i = DEPTH - 1; i >= 0; i--) if (!tbl_valid[i]) s = i;
          if (s >= 0) begin
            a.status = STATUS_INSERTED;
            tbl_valid[s] = 1'b1;
            tbl_mac[s] = c.mac;
            tbl_wl[s] = 1'b0;
          end else a.status = STATUS_FULL;
        end
        if (s >= 0) begin
          tbl_seen[s] = c.now;
          a.slot = s[4:0];
        end
      end
      FUNC_SWEEP: begin
        for (int i = 0; i < DEPTH; i++) begin
          age = c.now - tbl_seen[i];
          if (tbl_valid[i] && !tbl_wl[i] && age > offline_limit) begin
            tbl_valid[i] = 1'b0;
            a.removed++;
          end
        end
        a.status = STATUS_SWEPT;
      end
      FUNC_MARK: begin
        s = slot_of(c.mac);
        if (s >= 0) begin
          tbl_wl[s] = c.wl;
          a.status = STATUS_MARKED;
          a.slot = s[4:0];
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // Driver: present queued words, hold each until it is taken.
  always @(posedge clk) begin
    if (!rst) begin
      if (!in_valid || !in_stall) begin
        if (in_valid) expected_answers.push_back(table_update(cur));
        if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cur <= pending_cmds.pop_front();
          in_valid <= 1'b1;
        end else in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each taken result word with the oldest prediction.
  always @(posedge clk) begin
    answer_t exp_a, got;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = '{status, slot_index, removed_count, channel_number};
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected result word %p", $time, got);
          errors++;
        end else begin
          exp_a = expected_answers.pop_front();
          if (got.status !== exp_a.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_a.status, got.status);
            errors++;
          end
          if (got.slot !== exp_a.slot) begin
            $display("%0t: slot expected %0d actual %0d", $time, exp_a.slot, got.slot);
            errors++;
          end
          if (got.removed !== exp_a.removed) begin
            $display("%0t: removed expected %0d actual %0d", $time, exp_a.removed,
                     got.removed);
            errors++;
          end
          if (got.channel !== exp_a.channel) begin
            $display("%0t: channel expected %0d actual %0d", $time, exp_a.channel,
                     got.channel);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic write_offline(input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_OFFLINE; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    offline_limit = value;
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || in_valid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (DEPTH + 40) @(posedge clk);
  endtask

  function automatic logic [47:0] pick_mac();
    if (known_macs.size() > 0 && $urandom_range(99) < 80)
      return known_macs[$urandom_range(known_macs.size() - 1)];
    return 48'({$urandom, $urandom});
  endfunction

  // A random command; the time runs forward in small steps mostly.
  function automatic command_t random_command(inout logic [31:0] clock_s);
    command_t c;
    int r;
    r = $urandom_range(99);
    c.func = (r < 60) ? FUNC_REPORT : (r < 75) ? FUNC_SWEEP : (r < 95) ? FUNC_MARK : 2'd3;
    c.mac = pick_mac();
    c.rssi = 8'($urandom);
    c.tx_kbps = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
    c.legacy = 8'($urandom);
    c.rx_kbps = $urandom;
    c.assoc = $urandom;
    c.freq = ($urandom_range(1) == 0) ? 16'($urandom_range(2300, 6200)) : 16'($urandom);
    c.mode = ($urandom_range(1) == 0) ? 8'($urandom_range(30)) : 8'($urandom);
    clock_s = ($urandom_range(49) == 0) ? $urandom : clock_s + $urandom_range(40);
    c.now = clock_s;
    c.wl = 1'($urandom);
    return c;
  endfunction

  initial begin
    static int freqs[] = '{0, 2406, 2407, 2484, 2483, 2485, 2511, 2512, 4900, 4901,
                           4940, 4941, 4942, 4989, 4990, 5000, 65535};
    static logic [31:0] limits[] = '{32'd60, 32'd0, 32'hFFFF_FFFF, 32'd25};
    static int idles[] = '{0, 81, 0, 18};
    static int stalls[] = '{0, 0, 81, 18};
    command_t c;
    logic [31:0] clock_s;
    for (int i = 0; i < DEPTH; i++) begin
      tbl_valid[i] = 1'b0; tbl_wl[i] = 1'b0; tbl_seen[i] = '0; tbl_mac[i] = '0;
    end
    offline_limit = OFFLINE_SECONDS_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: frequency edges, field extremes, every command and func 3.
    clock_s = 100;
    foreach (freqs[i]) begin
      c = '0;
      c.func = FUNC_REPORT;
      c.mac = (i == 0) ? 48'd0 : (i == 1) ? 48'hFFFF_FFFF_FFFF : 48'h10 + 48'(i);
      c.rssi = (i % 2) ? 8'hFF : 8'h00;
      c.tx_kbps = (i % 3 == 0) ? 32'd0 : 32'hFFFF_FFFF;
      c.legacy = 8'hFF; c.rx_kbps = 32'hFFFF_FFFF; c.assoc = 32'hFFFF_FFFF;
      c.freq = 16'(freqs[i]); c.mode = (i % 2) ? 8'd22 : 8'd21;
      c.now = clock_s; c.wl = 1'b1;
      pending_cmds.push_back(c);
      known_macs.push_back(c.mac);
    end
    c.func = FUNC_MARK; c.mac = 48'd0; c.wl = 1'b1; pending_cmds.push_back(c);
    c.mac = 48'h1234; pending_cmds.push_back(c);
    c.func = 2'd3; pending_cmds.push_back(c);
    c.func = FUNC_SWEEP; c.now = 32'd160; pending_cmds.push_back(c);
    c.now = 32'd161; pending_cmds.push_back(c);
    c.func = FUNC_REPORT; c.mac = 48'hFFFF_FFFF_FFFF; c.now = 32'd161;
    pending_cmds.push_back(c);
    wait_drained();

    // Fill the table to overflow, then random phases under each limit.
    for (int i = 0; i < DEPTH + 3; i++) begin
      c = random_command(clock_s);
      c.func = FUNC_REPORT;
      c.mac = 48'hA0_0000 + 48'(i);
      known_macs.push_back(c.mac);
      pending_cmds.push_back(c);
    end
    wait_drained();

    foreach (limits[p]) begin
      write_offline(limits[p]);
      for (int ph = 0; ph < 4; ph++) begin
        idle_pct = idles[ph];
        stall_pct = stalls[ph];
        for (int k = 0; k < 100; k++) pending_cmds.push_back(random_command(clock_s));
        if (known_macs.size() > 60) known_macs = known_macs[$-40:$];
        // Sender holds off until all answers are in.
        while (pending_cmds.size() > 0 || in_valid) @(posedge clk);
        while (expected_answers.size() > 0) @(posedge clk);
      end
      idle_pct = 0;
      stall_pct = 0;
      wait_drained();
    end

    if (errors == 0 && expected_answers.size() == 0)
      $display("peer_station_table_aging_test: PASS");
    else
      $display("peer_station_table_aging_test: FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("peer_station_table_aging_test: FAIL");
    $finish;
  end

endmodule
